// ===== rtl/mfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mfq_pkg: shared types and constants
// Word layouts, codes and sizes for the feedback-queue scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfq_pkg;

  localparam int MaxTasks  = 64;
  localparam int TaskW     = $clog2(MaxTasks);
  localparam int NumLevels = 3;
  localparam int LvlW      = 2;
  localparam int FillW     = TaskW + 1;
  localparam int QAddrW    = LvlW + TaskW;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 20;

  localparam logic [15:0] QuantumTopRst    = 16'd10;
  localparam logic [15:0] QuantumMiddleRst = 16'd20;
  localparam logic [15:0] QuantumBottomRst = 16'd40;
  localparam logic [19:0] BoostIntervalRst = 20'd150;

  localparam logic KindAdmit    = 1'b0;
  localparam logic KindDispatch = 1'b1;

  typedef enum logic [1:0] {
    TS_FREE   = 2'd0,
    TS_ACTIVE = 2'd1,
    TS_DONE   = 2'd2,
    TS_RSVD   = 2'd3
  } task_state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUANTUM_TOP    = 2'd0,
    CFG_QUANTUM_MIDDLE = 2'd1,
    CFG_QUANTUM_BOTTOM = 2'd2,
    CFG_BOOST_INTERVAL = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        kind;
    logic [5:0]  task_id;
    logic [15:0] service_time;
    logic [31:0] arrival_time;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic        idle;
    logic [5:0]  served_task;
    logic [15:0] slice_length;
    logic [1:0]  new_level;
    logic        finished;
    logic [31:0] response_time;
    logic [31:0] turnaround_time;
    logic        boosted;
    logic [31:0] now_time;
    logic [31:0] switch_count;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/mfq_if.sv =====
// ----------------------------------------------------------------------------
// mfq_if: valid/ready channels
// Input and result channels of the scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mfq_in_if;
  logic               valid;
  logic               ready;
  mfq_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mfq_out_if;
  logic               valid;
  logic               ready;
  mfq_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mfq_front.sv =====
// ----------------------------------------------------------------------------
// mfq_front: input word queue
// Two-entry queue that takes words in and hands them to the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfq_front (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mfq_in_if.sink    in_i,
  mfq_in_if.source  cmd_o
);
  import mfq_pkg::*;

  in_word_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_i.ready  = (cnt_q != 2'd2);
  assign cmd_o.valid = (cnt_q != 2'd0);
  assign cmd_o.data  = mem_q[rd_ptr_q];
  assign push = in_i.valid && in_i.ready;
  assign pop  = cmd_o.valid && cmd_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mfq_back.sv =====
// ----------------------------------------------------------------------------
// mfq_back: scheduling engine
// Admits tasks, runs boosts and dispatch steps over the task and ring memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfq_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mfq_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [mfq_pkg::CfgDataW-1:0]     cfg_data_i,
  mfq_in_if.sink                                cmd_i,
  mfq_out_if.source                             out_o
);
  import mfq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_BOOST = 7'b0000010,
    S_PICK  = 7'b0000100,
    S_RDQ   = 7'b0001000,
    S_RDT   = 7'b0010000,
    S_EXEC  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [15:0] rem;
    logic [16:0] used;
    logic [31:0] arr;
    logic [31:0] start;
  } task_t;

  state_e state_q, state_d;

  logic [15:0] qtop_q, qmid_q, qbot_q;
  logic [19:0] bint_q;
  logic [31:0] clock_q, last_boost_q, sw_q;
  logic        any_q, boost_flag_q;
  logic [1:0]  status_q [MaxTasks];
  logic        started_q [MaxTasks];
  logic [TaskW-1:0] head_q [NumLevels];
  logic [FillW-1:0] fill_q [NumLevels];
  logic [TaskW-1:0] scan_q, slot_q;
  logic [LvlW-1:0]  lvl_q;
  logic [15:0] run_q;
  task_t       tr_q;
  out_word_t   res_q, res_d;

  // memories
  logic [TaskW-1:0] qmem [NumLevels*MaxTasks];
  task_t            tmem [MaxTasks];
  logic             q_we, t_we;
  logic [QAddrW-1:0] q_waddr, q_raddr;
  logic [TaskW-1:0] q_wdata, q_rdata, t_waddr, t_raddr;
  task_t            t_wdata, t_rdata;

  always_ff @(posedge clk_i) begin
    if (q_we) qmem[q_waddr] <= q_wdata;
    q_rdata <= qmem[q_raddr];
    if (t_we) tmem[t_waddr] <= t_wdata;
    t_rdata <= tmem[t_raddr];
  end

  // level selection
  logic             pick_ok;
  logic [LvlW-1:0]  pick_lvl;
  always_comb begin
    pick_ok  = 1'b0;
    pick_lvl = '0;
    for (int l = NumLevels - 1; l >= 0; l--) begin
      if (fill_q[l] != '0) begin
        pick_ok  = 1'b1;
        pick_lvl = LvlW'(l);
      end
    end
  end

  logic [15:0] q_cur;
  always_comb begin
    unique case (lvl_q)
      2'd0:    q_cur = qtop_q;
      2'd1:    q_cur = qmid_q;
      default: q_cur = qbot_q;
    endcase
  end

  // admit
  in_word_t    w;
  logic        adm_ok, boost_now;
  logic [31:0] clk_adm;
  assign w         = cmd_i.data;
  assign adm_ok    = (status_q[w.task_id] == TS_FREE);
  assign clk_adm   = (adm_ok && !any_q) ? w.arrival_time : clock_q;
  assign boost_now = ((clock_q - last_boost_q) >= {12'd0, bint_q});

  // dispatch arithmetic
  logic [31:0] start_v, clk_n;
  logic [15:0] rem_n;
  logic [17:0] used_sum;
  logic [16:0] used_sat;
  logic        fin, drop;
  logic [LvlW-1:0] nl;
  assign start_v  = started_q[slot_q] ? tr_q.start : clock_q;
  assign rem_n    = tr_q.rem - run_q;
  assign used_sum = {1'b0, tr_q.used} + {2'b00, run_q};
  assign used_sat = used_sum[17] ? 17'h1FFFF : used_sum[16:0];
  assign clk_n    = clock_q + {16'd0, run_q};
  assign fin      = (rem_n == 16'd0);
  assign drop     = (used_sat >= {1'b0, q_cur});
  assign nl       = (drop && lvl_q < LvlW'(NumLevels - 1)) ? lvl_q + 1'b1 : lvl_q;

  // result word, built up over the step
  always_comb begin
    res_d = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          res_d = '0;
          if (w.kind == KindAdmit) begin
            res_d.status       = !adm_ok;
            res_d.now_time     = clk_adm;
            res_d.switch_count = sw_q;
          end
        end
      end
      S_PICK: begin
        res_d.boosted = boost_flag_q;
        if (!pick_ok) begin
          res_d.idle         = 1'b1;
          res_d.now_time     = clock_q + 32'd1;
          res_d.switch_count = sw_q;
        end
      end
      S_EXEC: begin
        res_d.served_task  = slot_q;
        res_d.slice_length = run_q;
        res_d.finished     = fin;
        res_d.now_time     = clk_n;
        res_d.switch_count = sw_q + 32'd1;
        if (fin) begin
          res_d.response_time   = start_v - tr_q.arr;
          res_d.turnaround_time = clk_n - tr_q.arr;
        end else begin
          res_d.new_level = nl;
        end
      end
      default: ;
    endcase
  end

  assign cmd_i.ready = (state_q == S_IDLE);
  assign out_o.valid = (state_q == S_OUT);
  assign out_o.data  = res_q;

  always_comb begin
    state_d = state_q;
    q_we    = 1'b0;
    q_waddr = '0;
    q_wdata = '0;
    q_raddr = {pick_lvl, head_q[pick_lvl]};
    t_we    = 1'b0;
    t_waddr = w.task_id;
    t_wdata = '{rem: w.service_time, used: '0, arr: w.arrival_time, start: '0};
    t_raddr = slot_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          if (w.kind == KindAdmit) begin
            state_d = S_OUT;
            if (adm_ok) begin
              t_we    = 1'b1;
              q_we    = 1'b1;
              q_waddr = {LvlW'(0), head_q[0] + fill_q[0][TaskW-1:0]};
              q_wdata = w.task_id;
            end
          end else begin
            state_d = boost_now ? S_BOOST : S_PICK;
          end
        end
      end
      S_BOOST: begin
        q_we    = (status_q[scan_q] == TS_ACTIVE);
        q_waddr = {LvlW'(0), fill_q[0][TaskW-1:0]};
        q_wdata = scan_q;
        if (scan_q == TaskW'(MaxTasks - 1)) state_d = S_PICK;
      end
      S_PICK:  state_d = pick_ok ? S_RDQ : S_OUT;
      S_RDQ: begin
        t_raddr = q_rdata;
        state_d = S_RDT;
      end
      S_RDT:   state_d = S_EXEC;
      S_EXEC: begin
        t_we    = 1'b1;
        t_waddr = slot_q;
        t_wdata = '{rem: rem_n, used: drop ? 17'd0 : used_sat, arr: tr_q.arr,
                    start: start_v};
        q_we    = !fin;
        q_waddr = {nl, head_q[nl] + fill_q[nl][TaskW-1:0]};
        q_wdata = slot_q;
        state_d = S_OUT;
      end
      S_OUT:   if (out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_RDQ:   slot_q <= q_rdata;
      S_RDT: begin
        tr_q  <= t_rdata;
        run_q <= (t_rdata.rem < q_cur) ? t_rdata.rem : q_cur;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      qtop_q       <= QuantumTopRst;
      qmid_q       <= QuantumMiddleRst;
      qbot_q       <= QuantumBottomRst;
      bint_q       <= BoostIntervalRst;
      clock_q      <= '0;
      last_boost_q <= '0;
      sw_q         <= '0;
      any_q        <= 1'b0;
      boost_flag_q <= 1'b0;
      scan_q       <= '0;
      lvl_q        <= '0;
      res_q        <= '0;
      for (int i = 0; i < MaxTasks; i++) begin
        status_q[i]  <= TS_FREE;
        started_q[i] <= 1'b0;
      end
      for (int l = 0; l < NumLevels; l++) begin
        head_q[l] <= '0;
        fill_q[l] <= '0;
      end
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_QUANTUM_TOP:    qtop_q <= cfg_data_i[15:0];
          CFG_QUANTUM_MIDDLE: qmid_q <= cfg_data_i[15:0];
          CFG_QUANTUM_BOTTOM: qbot_q <= cfg_data_i[15:0];
          CFG_BOOST_INTERVAL: bint_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_i.valid) begin
            boost_flag_q <= (w.kind == KindDispatch) && boost_now;
            if (w.kind == KindAdmit) begin
              if (adm_ok) begin
                status_q[w.task_id]  <= TS_ACTIVE;
                started_q[w.task_id] <= 1'b0;
                fill_q[0] <= fill_q[0] + 1'b1;
                clock_q   <= clk_adm;
                any_q     <= 1'b1;
              end
            end else if (boost_now) begin
              scan_q       <= '0;
              for (int l = 0; l < NumLevels; l++) begin
                head_q[l] <= '0;
                fill_q[l] <= '0;
              end
            end
          end
        end
        S_BOOST: begin
          if (status_q[scan_q] == TS_ACTIVE) fill_q[0] <= fill_q[0] + 1'b1;
          scan_q <= scan_q + 1'b1;
          if (scan_q == TaskW'(MaxTasks - 1)) last_boost_q <= clock_q;
        end
        S_PICK: begin
          if (pick_ok) begin
            lvl_q            <= pick_lvl;
            head_q[pick_lvl] <= head_q[pick_lvl] + 1'b1;
            fill_q[pick_lvl] <= fill_q[pick_lvl] - 1'b1;
          end else begin
            clock_q <= clock_q + 32'd1;
          end
        end
        S_EXEC: begin
          started_q[slot_q] <= 1'b1;
          clock_q           <= clk_n;
          sw_q              <= sw_q + 32'd1;
          if (fin) begin
            status_q[slot_q] <= TS_DONE;
          end else begin
            fill_q[nl] <= fill_q[nl] + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/multilevel_feedback_queue_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_core: top level
// Three-level feedback-queue scheduler with periodic priority boost.
// ----------------------------------------------------------------------------
// Sequence: the front queue registers each word; an admit result word is valid in the
// cycle after the engine takes it; a dispatch passes pick, ring read, task read, exec
// (task and ring write) and out (pick then out when idle), after a boost walk over all
// task slots if one is due. A new word is taken only after the last result is accepted.
// Reset: async active low; clears clock, counters, ring pointers and task states,
// loads quanta 10/20/40 and boost interval 150.
`timescale 1ns / 1ps
`default_nettype none

module multilevel_feedback_queue_scheduler_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [mfq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mfq_pkg::CfgDataW-1:0] cfg_data_i,
  mfq_in_if.sink                            in_i,
  mfq_out_if.source                         out_o
);
  import mfq_pkg::*;

  // front queue decouples word intake from the sequencing engine
  mfq_in_if cmd_if ();

  mfq_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_o  (cmd_if.source)
  );

  // engine: admit, boost walk, level pick, ring pop, task update, result word
  mfq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_if.sink),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/mfq_checker.sv =====
// ----------------------------------------------------------------------------
// mfq_checker: result port checks
// Consistency checks on result words, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfq_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               valid_i,
  input wire logic               ready_i,
  input wire mfq_pkg::out_word_t word_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(word_i))
    else $error("result word dropped or changed while stalled");

  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && word_i.idle |-> word_i.served_task == 6'd0 &&
      word_i.slice_length == 16'd0 && !word_i.finished && !word_i.status)
    else $error("idle step reports a served task");

  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && word_i.status |-> !word_i.idle && !word_i.finished &&
      !word_i.boosted)
    else $error("rejected admit carries dispatch fields");

  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && word_i.finished |-> word_i.new_level == 2'd0)
    else $error("finished task reports a level");

endmodule

bind multilevel_feedback_queue_scheduler_core mfq_checker u_mfq_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .valid_i (out_o.valid),
  .ready_i (out_o.ready),
  .word_i  (out_o.data)
);

`default_nettype wire
